// ===== design/pqfd_pkg.sv =====
// Package for the multi-queue tail-drop FIFO: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
package pqfd_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int DEPTH      = 128;
    localparam int QW         = 2;
    localparam int PW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int MW         = $clog2(NUM_QUEUES * DEPTH);
    localparam int NUM_REGS   = 5;
    localparam int REGW       = 3;

    localparam logic [7:0] RESET_DEFAULT_CAPACITY = 8'd100;

    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_DEQ   = 3'd1;
    localparam logic [2:0] OP_STATS = 3'd2;
    localparam logic [2:0] OP_CLRQ  = 3'd3;
    localparam logic [2:0] OP_CLRA  = 3'd4;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_DEQUEUED = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    localparam logic [REGW-1:0] REG_DEFAULT_CAP = 3'd0;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  queue_index;
        logic [30:0] pkt_id;
        logic [31:0] now_time;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] out_pkt_id;
        logic [31:0] out_delay;
        logic [7:0]  fill_level;
        logic [31:0] enqueued_count;
        logic [31:0] dequeued_count;
        logic [31:0] dropped_count;
        logic [7:0]  max_size_seen;
        logic [31:0] min_delay_seen;
        logic [31:0] max_delay_seen;
        logic [47:0] delay_sum;
        logic [31:0] all_drops;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic busy;
    } t_stat;

endpackage

// ===== design/pqfd_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
// Depends on nothing; the payload type is a type parameter.
interface pqfd_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/pqfd_ctrl.sv =====
// Controller for the multi-queue FIFO: sequences capture and execute cycles
// and owns the output register handshake. Depends on pqfd_pkg.
module pqfd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pqfd_pkg::t_cmd o_cmd
);
    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // The output register frees as it is taken, so a new word may enter then.
    assign o_in_ready   = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.execute = (r_state == S_EXEC);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== design/pqfd_datapath.sv =====
// Datapath: capacity registers, queue pointers, statistics, packet memory
// and the result register. Depends on pqfd_pkg.
module pqfd_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pqfd_pkg::REGW-1:0] i_cfg_index,
    input  logic [7:0]                i_cfg_data,
    input  pqfd_pkg::t_cmd            i_cmd,
    input  pqfd_pkg::t_in_word        i_word,
    output pqfd_pkg::t_out_word       o_word
);
    localparam int NQ = pqfd_pkg::NUM_QUEUES;
    localparam int PW = pqfd_pkg::PW;
    localparam int CW = pqfd_pkg::CW;
    localparam int MW = pqfd_pkg::MW;
    localparam logic [31:0] MAX32 = '1;
    localparam logic [47:0] MAX48 = '1;

    logic [7:0]    r_default_cap;
    logic [7:0]    r_qcap [NQ];
    logic [PW-1:0] r_head [NQ];
    logic [CW-1:0] r_count [NQ];
    logic [31:0]   r_enq [NQ];
    logic [31:0]   r_deq [NQ];
    logic [31:0]   r_drop [NQ];
    logic [CW-1:0] r_peak [NQ];
    logic [31:0]   r_dmin [NQ];
    logic [31:0]   r_dmax [NQ];
    logic [47:0]   r_dsum [NQ];
    logic [31:0]   r_all_drops;

    logic [62:0]   r_mem [pqfd_pkg::NUM_QUEUES * pqfd_pkg::DEPTH];
    logic [62:0]   r_rd;
    pqfd_pkg::t_in_word  r_in;
    pqfd_pkg::t_out_word r_out;

    // Capture cycle: latch the word and read the head entry of its queue.
    logic [1:0] cq;
    assign cq = i_word.queue_index;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_word;
            r_rd <= r_mem[MW'({cq, r_head[cq]})];
        end
    end

    // Execute cycle.
    logic [1:0]    q;
    logic          q_ok;
    logic [7:0]    cap_raw;
    logic [CW-1:0] cap;
    logic [CW-1:0] cnt;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] tail;
    logic [31:0]   d;
    logic [48:0]   sum_ext;
    logic          do_enq, do_drop, do_deq;

    assign q    = r_in.queue_index;
    assign q_ok = 32'(q) < NQ;
    assign cnt  = r_count[q];

    always_comb begin
        cap_raw = (r_qcap[q] != 8'd0) ? r_qcap[q] : r_default_cap;
        if (32'(cap_raw) > pqfd_pkg::DEPTH) begin
            cap = CW'(pqfd_pkg::DEPTH);
        end else begin
            cap = CW'(cap_raw);
        end
    end

    assign tail_sum = (PW+1)'(r_head[q]) + (PW+1)'(cnt);
    assign tail     = tail_sum[PW-1:0];
    assign d        = r_in.now_time - r_rd[31:0];
    assign sum_ext  = {1'b0, r_dsum[q]} + 49'(d);
    assign do_enq   = i_cmd.execute && q_ok && r_in.op == pqfd_pkg::OP_ENQ && cnt < cap;
    assign do_drop  = i_cmd.execute && q_ok && r_in.op == pqfd_pkg::OP_ENQ && cnt >= cap;
    assign do_deq   = i_cmd.execute && q_ok && r_in.op == pqfd_pkg::OP_DEQ && cnt != '0;

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[MW'({q, tail})] <= {r_in.pkt_id, r_in.now_time};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_cap <= pqfd_pkg::RESET_DEFAULT_CAPACITY;
            r_all_drops   <= '0;
            for (int i = 0; i < NQ; i++) begin
                r_qcap[i]  <= '0;
                r_head[i]  <= '0;
                r_count[i] <= '0;
                r_enq[i]   <= '0;
                r_deq[i]   <= '0;
                r_drop[i]  <= '0;
                r_peak[i]  <= '0;
                r_dmin[i]  <= '0;
                r_dmax[i]  <= '0;
                r_dsum[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == pqfd_pkg::REG_DEFAULT_CAP) begin
                    if (i_cfg_data != 8'd0) begin
                        r_default_cap <= i_cfg_data;
                    end
                end else if (32'(i_cfg_index) <= NQ) begin
                    r_qcap[2'(i_cfg_index - 3'd1)] <= i_cfg_data;
                end
            end
            if (do_enq) begin
                r_count[q] <= cnt + 1'b1;
                if (r_enq[q] != MAX32) r_enq[q] <= r_enq[q] + 1'b1;
                if (cnt + 1'b1 > r_peak[q]) r_peak[q] <= cnt + 1'b1;
            end
            if (do_drop) begin
                if (r_drop[q] != MAX32) r_drop[q] <= r_drop[q] + 1'b1;
                if (r_all_drops != MAX32) r_all_drops <= r_all_drops + 1'b1;
            end
            if (do_deq) begin
                r_count[q] <= cnt - 1'b1;
                r_head[q]  <= r_head[q] + 1'b1;
                if (r_deq[q] == '0 || d < r_dmin[q]) r_dmin[q] <= d;
                if (r_deq[q] == '0 || d > r_dmax[q]) r_dmax[q] <= d;
                if (r_deq[q] != MAX32) r_deq[q] <= r_deq[q] + 1'b1;
                r_dsum[q] <= sum_ext[48] ? MAX48 : sum_ext[47:0];
            end
            if (i_cmd.execute && q_ok && r_in.op == pqfd_pkg::OP_CLRQ) begin
                r_head[q]  <= '0;
                r_count[q] <= '0;
            end
            if (i_cmd.execute && q_ok && r_in.op == pqfd_pkg::OP_CLRA) begin
                r_all_drops <= '0;
                for (int i = 0; i < NQ; i++) begin
                    r_head[i]  <= '0;
                    r_count[i] <= '0;
                    r_enq[i]   <= '0;
                    r_deq[i]   <= '0;
                    r_drop[i]  <= '0;
                    r_peak[i]  <= '0;
                    r_dmin[i]  <= '0;
                    r_dmax[i]  <= '0;
                    r_dsum[i]  <= '0;
                end
            end
        end
    end

    // Result word, formed from the post-update values of the execute cycle.
    pqfd_pkg::t_out_word n_out;
    logic                clr_all;
    assign clr_all = q_ok && r_in.op == pqfd_pkg::OP_CLRA;

    always_comb begin
        n_out           = '0;
        n_out.status    = pqfd_pkg::ST_DONE;
        n_out.all_drops = r_all_drops;
        if (q_ok && !clr_all) begin
            n_out.fill_level     = 8'(cnt);
            n_out.enqueued_count = r_enq[q];
            n_out.dequeued_count = r_deq[q];
            n_out.dropped_count  = r_drop[q];
            n_out.max_size_seen  = 8'(r_peak[q]);
            n_out.min_delay_seen = r_dmin[q];
            n_out.max_delay_seen = r_dmax[q];
            n_out.delay_sum      = r_dsum[q];
            case (r_in.op)
                pqfd_pkg::OP_ENQ: begin
                    if (cnt < cap) begin
                        n_out.status     = pqfd_pkg::ST_ACCEPTED;
                        n_out.fill_level = 8'(cnt + 1'b1);
                        if (r_enq[q] != MAX32) n_out.enqueued_count = r_enq[q] + 1'b1;
                        if (cnt + 1'b1 > r_peak[q]) n_out.max_size_seen = 8'(cnt + 1'b1);
                    end else begin
                        n_out.status = pqfd_pkg::ST_DROPPED;
                        if (r_drop[q] != MAX32) n_out.dropped_count = r_drop[q] + 1'b1;
                        if (r_all_drops != MAX32) n_out.all_drops = r_all_drops + 1'b1;
                    end
                end
                pqfd_pkg::OP_DEQ: begin
                    if (cnt == '0) begin
                        n_out.status = pqfd_pkg::ST_EMPTY;
                    end else begin
                        n_out.status        = pqfd_pkg::ST_DEQUEUED;
                        n_out.out_pkt_id    = r_rd[62:32];
                        n_out.out_delay     = d;
                        n_out.fill_level    = 8'(cnt - 1'b1);
                        if (r_deq[q] != MAX32) n_out.dequeued_count = r_deq[q] + 1'b1;
                        if (r_deq[q] == '0 || d < r_dmin[q]) n_out.min_delay_seen = d;
                        if (r_deq[q] == '0 || d > r_dmax[q]) n_out.max_delay_seen = d;
                        n_out.delay_sum = sum_ext[48] ? MAX48 : sum_ext[47:0];
                    end
                end
                pqfd_pkg::OP_CLRQ: n_out.fill_level = '0;
                default: ;
            endcase
        end else if (clr_all) begin
            n_out.all_drops = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;
endmodule

// ===== design/per_queue_fifo_tail_drop_stats.sv =====
// Top level of the multi-queue tail-drop FIFO with statistics.
// Depends on pqfd_pkg, pqfd_stream_if, pqfd_ctrl and pqfd_datapath.
//
// Usage: operation words arrive on i_in (enqueue, dequeue, read stats,
// clear queue, clear all) and each produces exactly one result word on
// o_out. The capacity registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user must write them only while no word is in
// flight, and the block itself does not enforce this. Each word passes
// through a capture cycle that reads the head entry from the packet
// memory, then an execute cycle that updates the pointers and statistics
// of the addressed queue and loads the result register. No new word is
// accepted before the execute cycle of the previous one is over.
// A waiting result does not block the next word being taken once the
// receiver takes the result; while the receiver stalls, the result is held
// and no new word is accepted.
// Reset empties all queues, clears all statistics and restores the default
// capacity of 100; packet memory contents are not cleared.
module per_queue_fifo_tail_drop_stats (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pqfd_pkg::REGW-1:0] i_cfg_index,
    input  logic [7:0]                i_cfg_data,
    pqfd_stream_if.sink               i_in,
    pqfd_stream_if.source             o_out
);
    pqfd_pkg::t_cmd cmd;

    pqfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    pqfd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_word      (i_in.data),
        .o_word      (o_out.data)
    );

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.execute)) else $error("capture during execute");
    a_exec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> cmd.execute) else $error("execute did not follow capture");
    a_result_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.execute |=> o_out.valid) else $error("no result after execute");
endmodule
